### src/heightmap_block_edge_blend_core_defines.svh
// Assertion macros for the heightmap block edge blend core.
`ifndef HEIGHTMAP_BLOCK_EDGE_BLEND_CORE_DEFINES_SVH
`define HEIGHTMAP_BLOCK_EDGE_BLEND_CORE_DEFINES_SVH

// Clocked assertion, off while in reset.
`define HBEB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same check written as an implication.
`define HBEB_ASSERT_IMP(lbl, ante, cons, msg) \
	`HBEB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### src/hbeb_pkg.sv
// Types and constants shared by the heightmap block edge blend core.
package hbeb_pkg;

	localparam int MAX_SIDE    = 4096;
	localparam int HEIGHT_W    = 32;
	localparam int REG_W       = 13;
	localparam int COORD_W     = 12;
	localparam int IDX_W       = 24;
	localparam int FRAC_W      = 16;
	localparam int QUO_W       = 18;
	localparam int DIV_STEPS   = 3;
	localparam int DIV_STAGES  = 6;
	localparam int DIV_FIRST   = 2;
	localparam int DIV_LAST    = DIV_FIRST + DIV_STAGES - 1;
	localparam int MUL_STAGE   = DIV_LAST + 1;
	localparam int NUM_STAGES  = MUL_STAGE + 1;
	localparam int CFG_IDX_W   = 3;
	localparam int DIFF_W      = HEIGHT_W + 1;
	localparam int PROD_W      = DIFF_W + QUO_W + 1;
	localparam int DELTA_W     = PROD_W - FRAC_W;

	localparam logic [REG_W-1:0] SIDE_LIMIT = REG_W'(MAX_SIDE);
	localparam logic [QUO_W-1:0] QUO_ONE    = QUO_W'(1 << FRAC_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_SIDE   = 3'd0,
		REG_ORIGIN_COL = 3'd1,
		REG_ORIGIN_ROW = 3'd2,
		REG_BLOCK_COLS = 3'd3,
		REG_BLOCK_ROWS = 3'd4,
		REG_BLEND_SPAN = 3'd5
	} reg_idx_t;

	// restoring divider state: partial remainder, quotient so far, dividend bits left
	typedef struct packed {
		logic [REG_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] nbits;
	} div_t;

	typedef struct packed {
		logic [COORD_W-1:0] gx;
		logic [COORD_W-1:0] gy;
		logic [REG_W-1:0]   side;
	} pos_t;

	typedef struct packed {
		logic                       in_map;
		logic signed [HEIGHT_W-1:0] bv;
		logic signed [HEIGHT_W-1:0] ev;
		logic signed [DIFF_W-1:0]   diff;
	} ctx_t;

endpackage

### src/heightmap_block_edge_blend_core.sv
// Top level: feathered edge blend of pasted block samples into a square heightmap.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  item in   | item_valid/ready     | col, row, block_value, existing_value
//  result    | res_valid/ready      | dest_index, new_value, write_enable
//  config    | cfg_we               | cfg_index, cfg_data
//
// Nine register stages: placement, six divider stages (three quotient bits each)
// that produce the weight, the blend multiply, and the output register.
// One item per cycle while the result channel is not stalled.
// Each stage holds while the one after it is full and stalled; empty stages still fill.
// arst_n clears the valid bits and loads the register reset values.
`include "heightmap_block_edge_blend_core_defines.svh"

module heightmap_block_edge_blend_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [hbeb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hbeb_pkg::REG_W-1:0]          cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [hbeb_pkg::COORD_W-1:0]        col,
	input  logic [hbeb_pkg::COORD_W-1:0]        row,
	input  logic signed [hbeb_pkg::HEIGHT_W-1:0] block_value,
	input  logic signed [hbeb_pkg::HEIGHT_W-1:0] existing_value,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic [hbeb_pkg::IDX_W-1:0]          dest_index,
	output logic signed [hbeb_pkg::HEIGHT_W-1:0] new_value,
	output logic                                write_enable
);
	import hbeb_pkg::*;

	logic [REG_W-1:0] map_side_q, origin_col_q, origin_row_q;
	logic [REG_W-1:0] block_cols_q, block_rows_q, blend_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_side_q   <= SIDE_LIMIT;
			origin_col_q <= '0;
			origin_row_q <= '0;
			block_cols_q <= REG_W'(1);
			block_rows_q <= REG_W'(1);
			blend_span_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAP_SIDE:   map_side_q   <= cfg_data;
				REG_ORIGIN_COL: origin_col_q <= cfg_data;
				REG_ORIGIN_ROW: origin_row_q <= cfg_data;
				REG_BLOCK_COLS: block_cols_q <= cfg_data;
				REG_BLOCK_ROWS: block_rows_q <= cfg_data;
				REG_BLEND_SPAN: blend_span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage enables ripple back from the output
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES+1:1] en;

	always_comb begin
		en[NUM_STAGES+1] = res_ready;
		for (int k = NUM_STAGES; k >= 1; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign item_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1])
				vld_q[1] <= item_valid;
			for (int k = 2; k <= NUM_STAGES; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// placement, bounds and edge distance
	logic [REG_W:0]   gx_c, gy_c;
	logic [REG_W-1:0] side_c, ecol_c, erow_c, espan_c, e_c, ep1_c;
	logic             inside_c;

	assign gx_c = {origin_col_q[REG_W-1], origin_col_q} + {2'b00, col};
	assign gy_c = {origin_row_q[REG_W-1], origin_row_q} + {2'b00, row};
	assign side_c = (map_side_q > SIDE_LIMIT) ? SIDE_LIMIT : map_side_q;
	assign inside_c = ({1'b0, col} < block_cols_q) && ({1'b0, row} < block_rows_q)
		&& !gx_c[REG_W] && !gy_c[REG_W]
		&& (gx_c[REG_W-1:0] < side_c) && (gy_c[REG_W-1:0] < side_c);

	assign ecol_c  = block_cols_q - {1'b0, col} - REG_W'(1);
	assign erow_c  = block_rows_q - {1'b0, row} - REG_W'(1);
	assign espan_c = blend_span_q - REG_W'(1);

	always_comb begin
		e_c = {1'b0, col};
		if (ecol_c < e_c)
			e_c = ecol_c;
		if ({1'b0, row} < e_c)
			e_c = {1'b0, row};
		if (erow_c < e_c)
			e_c = erow_c;
		if (espan_c < e_c)
			e_c = espan_c;
	end

	assign ep1_c = e_c + REG_W'(1);

	pos_t                       pos_s1;
	div_t                       div_s [1:DIV_LAST];
	div_t                       div_nx [DIV_FIRST:DIV_LAST];
	ctx_t                       ctx_s [1:MUL_STAGE];
	logic [IDX_W-1:0]           idx_s [DIV_FIRST:MUL_STAGE];
	logic signed [PROD_W-1:0]   prod_s8;
	logic [IDX_W-1:0]           idx_c;
	logic signed [DELTA_W-1:0]  delta_c;
	logic signed [DELTA_W-1:0]  sum_c;

	for (genvar g = DIV_FIRST; g <= DIV_LAST; g++) begin : g_div
		hbeb_div_stage u_div (
			.d_in    (div_s[g-1]),
			.divisor (blend_span_q),
			.d_out   (div_nx[g])
		);
	end

	assign idx_c = IDX_W'(({13'd0, pos_s1.gy} * {12'd0, pos_s1.side}) + {13'd0, pos_s1.gx});

	assign delta_c = prod_s8[PROD_W-1:FRAC_W];
	assign sum_c = {{(DELTA_W-HEIGHT_W){ctx_s[MUL_STAGE].ev[HEIGHT_W-1]}}, ctx_s[MUL_STAGE].ev}
		+ delta_c;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_s1.gx      <= gx_c[COORD_W-1:0];
			pos_s1.gy      <= gy_c[COORD_W-1:0];
			pos_s1.side    <= side_c;
			ctx_s[1].in_map <= inside_c;
			ctx_s[1].bv    <= block_value;
			ctx_s[1].ev    <= existing_value;
			ctx_s[1].diff  <= {block_value[HEIGHT_W-1], block_value}
				- {existing_value[HEIGHT_W-1], existing_value};
			// dividend is (e+1) << 16; its top bits seed the remainder
			div_s[1].rem   <= {2'b00, ep1_c[REG_W-1:2]};
			div_s[1].quo   <= '0;
			div_s[1].nbits <= {ep1_c[1:0], {(QUO_W-2){1'b0}}};
		end
		if (en[DIV_FIRST])
			idx_s[DIV_FIRST] <= idx_c;
		for (int k = DIV_FIRST; k <= DIV_LAST; k++) begin
			if (en[k]) begin
				div_s[k] <= div_nx[k];
				ctx_s[k] <= ctx_s[k-1];
			end
		end
		for (int k = DIV_FIRST + 1; k <= DIV_LAST; k++)
			if (en[k])
				idx_s[k] <= idx_s[k-1];
		if (en[MUL_STAGE]) begin
			ctx_s[MUL_STAGE] <= ctx_s[DIV_LAST];
			idx_s[MUL_STAGE] <= idx_s[DIV_LAST];
			prod_s8 <= ctx_s[DIV_LAST].diff * $signed({1'b0, div_s[DIV_LAST].quo});
		end
		if (en[NUM_STAGES]) begin
			write_enable <= ctx_s[MUL_STAGE].in_map;
			if (!ctx_s[MUL_STAGE].in_map) begin
				dest_index <= '0;
				new_value  <= '0;
			end else begin
				dest_index <= idx_s[MUL_STAGE];
				new_value  <= (blend_span_q == '0) ? ctx_s[MUL_STAGE].bv
					: sum_c[HEIGHT_W-1:0];
			end
		end
	end

	assign res_valid = vld_q[NUM_STAGES];

	`HBEB_ASSERT_IMP(a_ready_when_empty, !res_valid, item_ready,
		"input stalled while output register is empty")
	`HBEB_ASSERT_IMP(a_masked_fields, res_valid && !write_enable,
		(dest_index == '0) && (new_value == '0), "rejected sample carries nonzero fields")
	`HBEB_ASSERT_IMP(a_weight_range,
		vld_q[DIV_LAST] && ctx_s[DIV_LAST].in_map && (blend_span_q != '0),
		div_s[DIV_LAST].quo <= QUO_ONE, "feather weight above one")

endmodule

### src/hbeb_div_stage.sv
// Three steps of restoring division for the feather weight pipeline.
module hbeb_div_stage (
	input  hbeb_pkg::div_t                   d_in,
	input  logic [hbeb_pkg::REG_W-1:0]       divisor,
	output hbeb_pkg::div_t                   d_out
);
	import hbeb_pkg::*;

	always_comb begin
		div_t           d;
		logic [REG_W:0] trial;
		d = d_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {d.rem, d.nbits[QUO_W-1]};
			d.nbits = {d.nbits[QUO_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				d.rem = REG_W'(trial - {1'b0, divisor});
				d.quo = {d.quo[QUO_W-2:0], 1'b1};
			end else begin
				d.rem = trial[REG_W-1:0];
				d.quo = {d.quo[QUO_W-2:0], 1'b0};
			end
		end
		d_out = d;
	end

endmodule
